### src/deq_pkg.sv
// Shared types and constants for the double-ended queue unit.
`timescale 1ns / 1ps

package deq_pkg;

  // Ring depth; a power of two so that slot arithmetic wraps by truncation.
  localparam int DEPTH  = 64;
  localparam int DATA_W = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REVERSE    = 3'd4,
    OP_QUERY      = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One access to the ring store: optional write, optional read.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

endpackage

### src/deq_if.sv
// Valid/ready channel interfaces for the queue's operations and results.
`timescale 1ns / 1ps

interface deq_in_if;
  logic                       valid;
  logic                       ready;
  logic [deq_pkg::OP_W-1:0]   operation;
  logic [deq_pkg::DATA_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface deq_out_if;
  logic                       valid;
  logic                       ready;
  logic [deq_pkg::DATA_W-1:0] front_value;
  logic [deq_pkg::DATA_W-1:0] back_value;
  logic [deq_pkg::CNT_W-1:0]  entry_count;
  logic                       is_empty;
  logic [deq_pkg::STAT_W-1:0] status;

  modport source (output valid, output front_value, output back_value,
                  output entry_count, output is_empty, output status, input ready);
  modport sink   (input valid, input front_value, input back_value,
                  input entry_count, input is_empty, input status, output ready);
endinterface

### src/deq_store.sv
// Ring store: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module deq_store (
  input  logic                       clk,
  input  deq_pkg::mem_req_t          req,
  output logic [deq_pkg::DATA_W-1:0] rd_data
);

  logic [deq_pkg::DATA_W-1:0] mem [deq_pkg::DEPTH];
  logic [deq_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    // hold read data until the next read is issued
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/double_ended_queue_unit.sv
// Top level of the double-ended queue unit: control, end-word cache, result register.
//
// Usage:
//   in_ch  carries one operation item (push front/back, pop front/back,
//          reverse, query) with a 64-bit value used only by pushes.
//   out_ch returns exactly one result item per operation: front word,
//          back word, entry count, empty flag and status.
// An accepted operation is registered into the control state, and in the work
//   state its result is written to the output register. in_ch.ready is low
//   in the work state, so a new operation waits until the last one is through;
//   a pop's result also takes the end word fetched by the ring store's read.
// The words at both physical ends of the ring are cached in registers, so
//   pushes and queries never read the store; a pop reads at most one entry.
// Reversal flips a direction flag only; no data moves.
// Rejected operations (push when full, pop or reverse when empty) leave the
//   queue unchanged and report their status.
// Reset (rst_n low, synchronous) empties the queue and clears the direction
//   flag; store contents stay as they were and are never read before written.
// When the receiver stalls, the finished result waits in the output register;
//   one further operation may be accepted and then holds until the register
//   frees, after which in_ch.ready returns.
`timescale 1ns / 1ps

module double_ended_queue_unit (
  input  logic      clk,
  input  logic      rst_n,
  deq_in_if.sink    in_ch,
  deq_out_if.source out_ch
);

  typedef enum logic {
    S_IDLE,
    S_WORK
  } state_t;

  localparam logic [deq_pkg::CNT_W-1:0]  CNT_FULL = deq_pkg::CNT_W'(deq_pkg::DEPTH);
  localparam logic [deq_pkg::CNT_W-1:0]  CNT_ONE  = deq_pkg::CNT_W'(1);
  localparam logic [deq_pkg::ADDR_W-1:0] ADDR_ONE = deq_pkg::ADDR_W'(1);
  localparam logic [deq_pkg::ADDR_W-1:0] ADDR_TWO = deq_pkg::ADDR_W'(2);

  state_t                      state_r;
  logic [deq_pkg::ADDR_W-1:0]  head_r,  head_nxt;
  logic [deq_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic                        rev_r,   rev_nxt;
  logic [deq_pkg::DATA_W-1:0]  first_r, first_nxt;   // word at physical start
  logic [deq_pkg::DATA_W-1:0]  last_r,  last_nxt;    // word at physical end
  logic                        pend_first_r, pend_first_nxt;
  logic                        pend_last_r,  pend_last_nxt;
  deq_pkg::status_t            status_r, status_nxt;

  logic                        out_valid_r;
  logic [deq_pkg::DATA_W-1:0]  out_front_r, out_back_r;
  logic [deq_pkg::CNT_W-1:0]   out_count_r;
  logic                        out_empty_r;
  deq_pkg::status_t            out_status_r;

  deq_pkg::mem_req_t           mem_req;
  logic [deq_pkg::DATA_W-1:0]  rd_data;

  logic                        accept;
  logic                        out_free;
  logic                        is_empty_q;
  logic                        is_full_q;
  logic                        to_start;
  logic [deq_pkg::ADDR_W-1:0]  tail_off;
  logic [deq_pkg::DATA_W-1:0]  eff_first, eff_last;
  deq_pkg::op_t                op;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign op         = deq_pkg::op_t'(in_ch.operation);
  assign is_empty_q = (count_r == '0);
  assign is_full_q  = (count_r == CNT_FULL);
  assign tail_off   = count_r[deq_pkg::ADDR_W-1:0];

  // Store never sees a read and a write to the same entry in one cycle: a
  // pop reads a held entry and writes nothing, so no forwarding is needed.
  deq_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Decode the accepted operation into new pointers and one store access.
  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    rev_nxt        = rev_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    pend_first_nxt = 1'b0;
    pend_last_nxt  = 1'b0;
    status_nxt     = deq_pkg::ST_DONE;
    to_start       = 1'b0;
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = head_r;
    mem_req.wr_data = in_ch.value;
    mem_req.rd_en   = 1'b0;
    mem_req.rd_addr = head_r;

    unique case (op)
      deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
        to_start = (op == deq_pkg::OP_PUSH_FRONT) ^ rev_r;
        if (is_full_q) begin
          status_nxt = deq_pkg::ST_FULL;
        end else begin
          count_nxt     = count_r + CNT_ONE;
          mem_req.wr_en = accept;
          if (to_start) begin
            head_nxt        = head_r - ADDR_ONE;
            mem_req.wr_addr = head_r - ADDR_ONE;
            first_nxt       = in_ch.value;
            if (is_empty_q) begin
              last_nxt = in_ch.value;
            end
          end else begin
            mem_req.wr_addr = head_r + tail_off;
            last_nxt        = in_ch.value;
            if (is_empty_q) begin
              first_nxt = in_ch.value;
            end
          end
        end
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
        to_start = (op == deq_pkg::OP_POP_FRONT) ^ rev_r;
        if (is_empty_q) begin
          status_nxt = deq_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_ONE;
          if (to_start) begin
            // fetch the word that becomes the new physical start
            head_nxt        = head_r + ADDR_ONE;
            mem_req.rd_addr = head_r + ADDR_ONE;
            pend_first_nxt  = (count_r != CNT_ONE);
          end else begin
            // fetch the word that becomes the new physical end
            mem_req.rd_addr = head_r + tail_off - ADDR_TWO;
            pend_last_nxt   = (count_r != CNT_ONE);
          end
          mem_req.rd_en = accept && (count_r != CNT_ONE);
        end
      end
      deq_pkg::OP_REVERSE: begin
        if (is_empty_q) begin
          status_nxt = deq_pkg::ST_EMPTY;
        end else begin
          rev_nxt = !rev_r;
        end
      end
      default: begin
        // query and unused codes: report state only
      end
    endcase
  end

  // End words as seen after the operation, taking any fetched word.
  assign eff_first = pend_first_r ? rd_data : first_r;
  assign eff_last  = pend_last_r  ? rd_data : last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      rev_r        <= 1'b0;
      pend_first_r <= 1'b0;
      pend_last_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          // drop the result once the receiver takes it
          if (out_valid_r && out_ch.ready) begin
            out_valid_r <= 1'b0;
          end
          if (accept) begin
            head_r       <= head_nxt;
            count_r      <= count_nxt;
            rev_r        <= rev_nxt;
            first_r      <= first_nxt;
            last_r       <= last_nxt;
            pend_first_r <= pend_first_nxt;
            pend_last_r  <= pend_last_nxt;
            status_r     <= status_nxt;
            state_r      <= S_WORK;
          end
        end
        S_WORK: begin
          // hold here while the previous result is still unclaimed
          if (out_free) begin
            first_r      <= eff_first;
            last_r       <= eff_last;
            pend_first_r <= 1'b0;
            pend_last_r  <= 1'b0;
            out_valid_r  <= 1'b1;
            out_count_r  <= count_r;
            out_empty_r  <= (count_r == '0);
            out_status_r <= status_r;
            if (count_r == '0) begin
              out_front_r <= '0;
              out_back_r  <= '0;
            end else if (rev_r) begin
              out_front_r <= eff_last;
              out_back_r  <= eff_first;
            end else begin
              out_front_r <= eff_first;
              out_back_r  <= eff_last;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.front_value = out_front_r;
  assign out_ch.back_value  = out_back_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.is_empty    = out_empty_r;
  assign out_ch.status      = out_status_r;

  // Count never passes the ring depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("entry count above depth");

  // A pending fetch only exists while words are held.
  a_fetch_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_first_r || pend_last_r) |-> (count_r != '0))
    else $error("store fetch pending on an empty queue");

  // At most one end word is fetched per operation.
  a_one_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_first_r && pend_last_r))
    else $error("both end words fetched at once");

  // Every accepted operation moves into the result cycle.
  a_accept_work: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_WORK))
    else $error("accepted item not processed");

  // An empty result carries zero words.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |->
      (out_front_r == '0 && out_back_r == '0 && out_count_r == '0))
    else $error("empty result carries data");

endmodule
